// ===== rtl/pfb_pkg.sv =====
// ----------------------------------------------------------------------------
// Page frame buffer package
// Shared constants, operation codes and the controller/datapath interface
// types of the page frame buffer bit writer.
// ----------------------------------------------------------------------------
package pfb_pkg;

    // Default geometry: columns per page and pages of eight pixel rows.
    localparam int COLUMNS_DEF = 128;
    localparam int PAGES_DEF   = 8;

    // Input word and result word widths (whole bytes).
    localparam int IN_W  = 40;
    localparam int OUT_W = 16;

    // Operation codes; codes above the last one behave as a byte read.
    typedef enum logic [2:0] {
        FUNC_SET_PIXEL = 3'd0,
        FUNC_SET_BYTE  = 3'd1,
        FUNC_SET_BITS  = 3'd2,
        FUNC_CLEAR_ALL = 3'd3,
        FUNC_READ_BYTE = 3'd4
    } func_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept_load; // capture the incoming word and its decode
        logic rd_spill;    // read the byte below the addressed one
        logic wr_first;    // write back the merged addressed byte
        logic wr_second;   // write back the merged spill byte
        logic wr_clear;    // zero the byte at the sweep counter
        logic clr_rst;     // restart the sweep counter
        logic res_load;    // hold the merged addressed byte as the result
        logic out_load;    // load the output register
        logic out_held;    // take the held result rather than the fresh merge
    } pfb_cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_clear;    // incoming word asks for a clear of the store
        logic spill;       // captured operation also touches the next page
        logic clr_last;    // sweep counter is at the last byte
        logic out_free;    // output register can take a result this cycle
    } pfb_status_t;

endpackage

// ===== rtl/pfb_ctrl.sv =====
// ----------------------------------------------------------------------------
// Page frame buffer controller
// Sequences the read-modify-write of each operation, the clearing sweep
// after reset and on a clear request, and the hand-off of each result.
// ----------------------------------------------------------------------------
module pfb_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  pfb_pkg::pfb_status_t st,
    output pfb_pkg::pfb_cmd_t    cmd
);
    import pfb_pkg::*;

    typedef enum logic [2:0] {
        S_INIT,
        S_IDLE,
        S_MERGE0,
        S_MERGE1,
        S_CLEAR,
        S_PUSH
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   accept;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Next state and commands for the datapath.
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_INIT: begin
                cmd.wr_clear = 1'b1;
                if (st.clr_last) begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE: begin
                cmd.clr_rst = 1'b1;
                if (accept) begin
                    cmd.accept_load = 1'b1;
                    state_next = st.in_clear ? S_CLEAR : S_MERGE0;
                end
            end
            S_MERGE0: begin
                cmd.wr_first = 1'b1;
                cmd.res_load = 1'b1;
                if (st.spill) begin
                    cmd.rd_spill = 1'b1;
                    state_next   = S_MERGE1;
                end else if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_MERGE1: begin
                cmd.wr_second = 1'b1;
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_held = 1'b1;
                    state_next   = S_IDLE;
                end else begin
                    state_next = S_PUSH;
                end
            end
            S_CLEAR: begin
                cmd.wr_clear = 1'b1;
                if (st.clr_last) begin
                    if (st.out_free) begin
                        cmd.out_load = 1'b1;
                        cmd.out_held = 1'b1;
                        state_next   = S_IDLE;
                    end else begin
                        state_next = S_PUSH;
                    end
                end
            end
            S_PUSH: begin
                if (st.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.out_held = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register; reset starts the clearing sweep.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_INIT;
        end else begin
            state_reg <= state_next;
        end
    end

    // A clear request goes straight into the sweep.
    a_clear_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && st.in_clear) |=> (state_reg == S_CLEAR))
        else $error("clear request did not start the sweep");

    // A result is never loaded over one that is still waiting.
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> st.out_free)
        else $error("output register overwritten");

    // An operation that spills always writes the second byte next.
    a_spill_seq: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_MERGE0 && st.spill) |=> (state_reg == S_MERGE1 && cmd.wr_second))
        else $error("spill byte not written after the first byte");

endmodule

// ===== rtl/pfb_datapath.sv =====
// ----------------------------------------------------------------------------
// Page frame buffer datapath
// Decodes each input word into an address, a bit mask and merge bits, holds
// the pixel store, merges read bytes and drives the output register.
// ----------------------------------------------------------------------------
module pfb_datapath #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic [pfb_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    output logic [pfb_pkg::OUT_W-1:0] m_tdata,
    input  pfb_pkg::pfb_cmd_t         cmd,
    output pfb_pkg::pfb_status_t      st
);
    import pfb_pkg::*;

    localparam int DEPTH  = COLUMNS * PAGES;
    localparam int ADDR_W = $clog2(DEPTH);

    // Input fields.
    func_t       func_in;
    logic [7:0]  col_in;
    logic [7:0]  row_in;
    logic [7:0]  page_in;
    logic [7:0]  data_in;
    logic [3:0]  len_in;
    logic        inv_in;

    assign func_in = func_t'(s_tdata[2:0]);
    assign col_in  = s_tdata[10:3];
    assign row_in  = s_tdata[18:11];
    assign page_in = s_tdata[26:19];
    assign data_in = s_tdata[34:27];
    assign len_in  = s_tdata[38:35];
    assign inv_in  = s_tdata[39];

    // Decode of the incoming word.
    logic [4:0]        rpg;
    logic [2:0]        rbit;
    logic [7:0]        apg;
    logic [7:0]        val;
    logic [3:0]        run_len;
    logic              col_ok;
    logic              loc_ok;
    logic              next_pg_ok;
    logic [15:0]       mask_in;
    logic [15:0]       bits_in;
    logic              wr_ok_in;
    logic              spill_in;
    logic [16:0]       lin_addr;
    logic [ADDR_W-1:0] addr_in;

    assign rpg     = row_in[7:3];
    assign rbit    = row_in[2:0];
    assign val     = inv_in ? ~data_in : data_in;
    assign run_len = (len_in > 4'd8) ? 4'd8 : len_in;
    assign apg     = (func_in == FUNC_SET_PIXEL || func_in == FUNC_SET_BITS)
                     ? {3'b000, rpg} : page_in;

    assign col_ok     = {1'b0, col_in} < 9'(COLUMNS);
    assign loc_ok     = col_ok && (apg < 8'(PAGES));
    assign next_pg_ok = ({3'b000, rpg} + 8'd1) < 8'(PAGES);

    // Linear byte address; out of range locations read address zero.
    assign lin_addr = 17'(apg) * 17'(COLUMNS) + 17'(col_in);
    assign addr_in  = loc_ok ? lin_addr[ADDR_W-1:0] : '0;

    // Mask and merge bits, two bytes wide for a run that crosses pages.
    always_comb begin
        mask_in  = '0;
        bits_in  = '0;
        wr_ok_in = 1'b0;
        unique case (func_in)
            FUNC_SET_PIXEL: begin
                mask_in  = 16'h0001 << rbit;
                bits_in  = inv_in ? 16'h0000 : mask_in;
                wr_ok_in = loc_ok;
            end
            FUNC_SET_BYTE: begin
                mask_in  = 16'h00ff;
                bits_in  = {8'h00, val};
                wr_ok_in = loc_ok;
            end
            FUNC_SET_BITS: begin
                mask_in  = ((16'h0001 << run_len) - 16'h0001) << rbit;
                bits_in  = ({8'h00, val} << rbit) & mask_in;
                wr_ok_in = loc_ok;
            end
            default: begin
                mask_in  = '0;
                bits_in  = '0;
                wr_ok_in = 1'b0;
            end
        endcase
    end

    assign spill_in = wr_ok_in && (func_in == FUNC_SET_BITS)
                      && (mask_in[15:8] != 8'h00) && next_pg_ok;

    // Captured operation.
    logic [ADDR_W-1:0] addr0_reg;
    logic [ADDR_W-1:0] addr1;
    logic [15:0]       mask_reg;
    logic [15:0]       bits_reg;
    logic              wr_ok_reg;
    logic              spill_reg;
    logic              ok_reg;
    logic [7:0]        res_data_reg;
    logic              res_ok_reg;

    assign addr1 = addr0_reg + ADDR_W'(COLUMNS);

    always_ff @(posedge aclk) begin
        if (cmd.accept_load) begin
            addr0_reg <= addr_in;
            mask_reg  <= mask_in;
            bits_reg  <= bits_in;
            wr_ok_reg <= wr_ok_in;
            spill_reg <= spill_in;
            ok_reg    <= loc_ok;
        end
    end

    // Pixel store with one write and one registered read port.
    logic [7:0]        store [DEPTH];
    logic [ADDR_W-1:0] rd_addr;
    logic [7:0]        rd_data_reg;
    logic [ADDR_W-1:0] wr_addr;
    logic [7:0]        wr_data;
    logic              wr_en;
    logic [ADDR_W-1:0] clr_cnt_reg;
    logic [7:0]        merge0;
    logic [7:0]        merge1;

    assign merge0 = (rd_data_reg & ~mask_reg[7:0]) | (bits_reg[7:0] & mask_reg[7:0]);
    assign merge1 = (rd_data_reg & ~mask_reg[15:8]) | (bits_reg[15:8] & mask_reg[15:8]);

    assign rd_addr = cmd.rd_spill ? addr1 : addr_in;

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = clr_cnt_reg;
        wr_data = 8'h00;
        priority if (cmd.wr_clear) begin
            wr_en = 1'b1;
        end else if (cmd.wr_first) begin
            wr_en   = wr_ok_reg;
            wr_addr = addr0_reg;
            wr_data = merge0;
        end else if (cmd.wr_second) begin
            wr_en   = spill_reg;
            wr_addr = addr1;
            wr_data = merge1;
        end else begin
            wr_en = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        rd_data_reg <= store[rd_addr];
        if (wr_en) begin
            store[wr_addr] <= wr_data;
        end
    end

    // Sweep counter for clearing the store.
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_rst) begin
            clr_cnt_reg <= '0;
        end else if (cmd.wr_clear) begin
            clr_cnt_reg <= clr_cnt_reg + ADDR_W'(1);
        end
    end

    // Held result: a clear reports zero, a merge its addressed byte.
    always_ff @(posedge aclk) begin
        if (cmd.accept_load) begin
            res_data_reg <= 8'h00;
            res_ok_reg   <= loc_ok;
        end else if (cmd.res_load) begin
            res_data_reg <= ok_reg ? merge0 : 8'h00;
            res_ok_reg   <= ok_reg;
        end
    end

    // Output register.
    logic       out_valid_reg;
    logic [7:0] out_data_reg;
    logic       out_ok_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_held) begin
                out_data_reg <= res_data_reg;
                out_ok_reg   <= res_ok_reg;
            end else begin
                out_data_reg <= ok_reg ? merge0 : 8'h00;
                out_ok_reg   <= ok_reg;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'b0000000, out_ok_reg, out_data_reg};

    // Status for the controller.
    assign st.in_clear = (func_in == FUNC_CLEAR_ALL);
    assign st.spill    = spill_reg;
    assign st.clr_last = (clr_cnt_reg == ADDR_W'(DEPTH - 1));
    assign st.out_free = !out_valid_reg || m_tready;

endmodule

// ===== rtl/page_frame_buffer_bit_writer.sv =====
// Flow: the block takes no new word until the result of the last one is in the
// output register; a run of bits that spills into the next page writes a
// second byte first, and a clear sweeps the whole store first. This is set by
// the read-modify-write through the single write port of the pixel store.
// Reset: the store is swept to zero, one byte a cycle, with s_tready low; the
// output register comes up empty.
// ----------------------------------------------------------------------------
// Page frame buffer bit writer
// Monochrome frame buffer of pages of eight vertical pixels per byte, with
// pixel, byte and bit-run writes, a clear of the whole store and byte reads.
// ----------------------------------------------------------------------------
module page_frame_buffer_bit_writer #(
    parameter int COLUMNS = pfb_pkg::COLUMNS_DEF,
    parameter int PAGES   = pfb_pkg::PAGES_DEF
) (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      s_tvalid,
    output logic                      s_tready,
    // func[2:0], column[10:3], row[18:11], page[26:19], data[34:27],
    // length[38:35], invert[39]
    input  logic [pfb_pkg::IN_W-1:0]  s_tdata,
    output logic                      m_tvalid,
    input  logic                      m_tready,
    // read_data[7:0], in_range[8], zero fill above
    output logic [pfb_pkg::OUT_W-1:0] m_tdata
);
    import pfb_pkg::*;

    pfb_cmd_t    cmd;
    pfb_status_t st;

    pfb_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .st       (st),
        .cmd      (cmd)
    );

    pfb_datapath #(
        .COLUMNS (COLUMNS),
        .PAGES   (PAGES)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .cmd      (cmd),
        .st       (st)
    );

endmodule

// ===== tb/page_frame_buffer_bit_writer_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Page frame buffer bit writer testbench
// Drives pixel, byte and bit-run writes, clears and byte reads into the
// block. A local copy of the pixel store predicts the byte and range flag
// of every result. A directed opening covers the edges of the buffer, spills
// and odd lengths. Random traffic follows under several idle and stall
// patterns on both sides.
// ----------------------------------------------------------------------------
module page_frame_buffer_bit_writer_tb;
    import pfb_pkg::*;

    localparam int FRAME_BYTES = COLUMNS_DEF * PAGES_DEF;

    logic              aclk     = 1'b0;
    logic              aresetn  = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata  = '0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;

    // Words waiting to be sent, and {in_range, read_data} still to come back.
    logic [IN_W-1:0]   pending_words[$];
    logic [8:0]        expected_bytes[$];
    // Local copy of the pixel store, updated as each word is accepted.
    logic [7:0]        pixel_mem [0:FRAME_BYTES-1];
    int                err_count     = 0;
    int                send_idle_pct = 0;
    int                recv_stall_pct = 0;

    page_frame_buffer_bit_writer dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    // 8 ns clock.
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    function automatic bit in_frame(int pg, int col);
        return pg < PAGES_DEF && col < COLUMNS_DEF;
    endfunction

    function automatic int frame_index(int pg, int col);
        return pg * COLUMNS_DEF + col;
    endfunction

    // Replace the masked bits of one byte, if that byte exists.
    function automatic void merge_byte(int pg, int col, logic [7:0] bits, logic [7:0] mask);
        int idx;
        if (in_frame(pg, col)) begin
            idx = frame_index(pg, col);
            pixel_mem[idx] = (pixel_mem[idx] & ~mask) | (bits & mask);
        end
    endfunction

    // Applies one word to the local store and returns {in_range, read_data}.
    function automatic logic [8:0] apply_op(logic [IN_W-1:0] w);
        logic [2:0]  op;
        logic [7:0]  col, row, pg, dat, wval;
        logic [3:0]  len;
        logic        inv;
        logic [15:0] run_mask, run_bits;
        int          apg, n;
        {inv, len, dat, pg, row, col, op} = w;
        wval = inv ? ~dat : dat;
        apg  = pg;
        case (op)
            FUNC_SET_PIXEL: begin
                apg = row >> 3;
                if (in_frame(apg, col))
                    pixel_mem[frame_index(apg, col)][row[2:0]] = ~inv;
            end
            FUNC_SET_BYTE: begin
                merge_byte(pg, col, wval, 8'hff);
            end
            FUNC_SET_BITS: begin
                // A run may cross into the next page; lengths above 8 saturate.
                apg      = row >> 3;
                n        = (len > 8) ? 8 : len;
                run_mask = ((16'd1 << n) - 16'd1) << row[2:0];
                run_bits = ({8'h00, wval} << row[2:0]) & run_mask;
                if (in_frame(apg, col)) begin
                    merge_byte(apg, col, run_bits[7:0], run_mask[7:0]);
                    merge_byte(apg + 1, col, run_bits[15:8], run_mask[15:8]);
                end
            end
            FUNC_CLEAR_ALL: begin
                foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
            end
            default: ;
        endcase
        if (in_frame(apg, col))
            return {1'b1, pixel_mem[frame_index(apg, col)]};
        return 9'd0;
    endfunction

    task automatic queue_op(logic [2:0] op, logic [7:0] col, logic [7:0] row,
                            logic [7:0] pg, logic [7:0] dat, logic [3:0] len, logic inv);
        pending_words.push_back({inv, len, dat, pg, row, col, op});
    endtask

    // Mostly in-range addresses in a narrow window so writes are read back.
    task automatic queue_random_op();
        logic [2:0] op;
        logic [7:0] col, row, pg;
        logic [3:0] len;
        int         r;
        r = $urandom_range(199);
        if (r < 2)         op = FUNC_CLEAR_ALL;
        else if (r < 52)   op = FUNC_SET_PIXEL;
        else if (r < 92)   op = FUNC_SET_BYTE;
        else if (r < 152)  op = FUNC_SET_BITS;
        else if (r < 190)  op = FUNC_READ_BYTE;
        else               op = 3'(FUNC_READ_BYTE + 1 + $urandom_range(2));
        r = $urandom_range(9);
        if (r < 5)
            col = 8'($urandom_range(3) + (($urandom_range(1) != 0) ? 124 : 0));
        else if (r < 8)
            col = 8'($urandom_range(COLUMNS_DEF - 1));
        else
            col = 8'($urandom_range(255));
        row = 8'(($urandom_range(4) != 0) ? $urandom_range(8 * PAGES_DEF - 1)
                                          : $urandom_range(255));
        pg  = 8'(($urandom_range(4) != 0) ? $urandom_range(PAGES_DEF - 1)
                                          : $urandom_range(255));
        len = 4'(($urandom_range(4) != 0) ? $urandom_range(8) : $urandom_range(15));
        queue_op(op, col, row, pg, 8'($urandom_range(255)), len, 1'($urandom_range(1)));
    endtask

    // Sender: presents the next word, with random gaps, and predicts each
    // word as it is taken.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid)
                expected_bytes.push_back(apply_op(s_tdata));
            if (pending_words.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_words.pop_front();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random back-pressure, and a check of every result word.
    always @(posedge aclk) begin
        logic [8:0] want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_bytes.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result word %h", $time, m_tdata);
                end else begin
                    want = expected_bytes.pop_front();
                    if (m_tdata[7:0] !== want[7:0]) begin
                        err_count++;
                        $display("%0t: read_data expected %h actual %h",
                                 $time, want[7:0], m_tdata[7:0]);
                    end
                    if (m_tdata[8] !== want[8]) begin
                        err_count++;
                        $display("%0t: in_range expected %b actual %b",
                                 $time, want[8], m_tdata[8]);
                    end
                end
            end
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Waits until every queued word has been taken and answered.
    task automatic drain();
        while (pending_words.size() > 0 || s_tvalid || expected_bytes.size() > 0)
            @(posedge aclk);
    endtask

    // Stimulus and end of run.
    initial begin
        foreach (pixel_mem[i]) pixel_mem[i] = 8'h00;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Pixels at the corners, out of range rows and columns, and clearing.
        queue_op(FUNC_SET_PIXEL, 8'd0,   8'd0,   8'd0, 8'h00, 4'd0, 1'b0);
        queue_op(FUNC_SET_PIXEL, 8'd127, 8'd63,  8'd0, 8'hff, 4'd15, 1'b0);
        queue_op(FUNC_SET_PIXEL, 8'd0,   8'd255, 8'd0, 8'h00, 4'd0, 1'b0);
        queue_op(FUNC_SET_PIXEL, 8'd128, 8'd3,   8'd0, 8'h00, 4'd0, 1'b0);
        queue_op(FUNC_SET_PIXEL, 8'd127, 8'd63,  8'd7, 8'h00, 4'd0, 1'b1);
        // Whole bytes, plain and inverted, and an out of range page.
        queue_op(FUNC_SET_BYTE,  8'd127, 8'd0,   8'd7,   8'hff, 4'd0, 1'b0);
        queue_op(FUNC_SET_BYTE,  8'd5,   8'd0,   8'd8,   8'hff, 4'd0, 1'b0);
        queue_op(FUNC_SET_BYTE,  8'd5,   8'd0,   8'd2,   8'h0f, 4'd0, 1'b1);
        queue_op(FUNC_SET_BYTE,  8'd255, 8'd0,   8'd255, 8'h5a, 4'd0, 1'b0);
        // Bit runs: spill into the next page, spill past the last page,
        // zero length, and a length that saturates at eight.
        queue_op(FUNC_SET_BITS,  8'd10,  8'd5,   8'd0, 8'hff, 4'd8,  1'b0);
        queue_op(FUNC_READ_BYTE, 8'd10,  8'd0,   8'd1, 8'h00, 4'd0,  1'b0);
        queue_op(FUNC_SET_BITS,  8'd10,  8'd61,  8'd0, 8'hff, 4'd8,  1'b0);
        queue_op(FUNC_SET_BITS,  8'd11,  8'd16,  8'd0, 8'hff, 4'd0,  1'b0);
        queue_op(FUNC_SET_BITS,  8'd12,  8'd20,  8'd0, 8'ha5, 4'd15, 1'b0);
        queue_op(FUNC_SET_BITS,  8'd12,  8'd0,   8'd0, 8'ha5, 4'd3,  1'b1);
        queue_op(FUNC_SET_BITS,  8'd200, 8'd0,   8'd0, 8'hff, 4'd8,  1'b0);
        // Reads in and out of range, and the spare operation codes.
        queue_op(FUNC_READ_BYTE, 8'd127, 8'd0,   8'd7,   8'h00, 4'd0, 1'b0);
        queue_op(FUNC_READ_BYTE, 8'd255, 8'd255, 8'd255, 8'hff, 4'd15, 1'b1);
        for (int k = FUNC_READ_BYTE + 1; k < 8; k++)
            queue_op(3'(k), 8'd5, 8'd0, 8'd2, 8'hff, 4'd8, 1'b1);
        // Clear everything, then read back bytes that were set.
        queue_op(FUNC_CLEAR_ALL, 8'd200, 8'd9,   8'd40, 8'h33, 4'd2, 1'b0);
        queue_op(FUNC_READ_BYTE, 8'd127, 8'd0,   8'd7,  8'h00, 4'd0, 1'b0);
        queue_op(FUNC_READ_BYTE, 8'd5,   8'd0,   8'd2,  8'h00, 4'd0, 1'b0);
        drain();

        // Random traffic, cycling through the idle and stall patterns.
        for (int chunk = 0; chunk < 8; chunk++) begin
            case (chunk % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
                default: begin send_idle_pct = 33; recv_stall_pct = 33; end
            endcase
            repeat (140) queue_random_op();
            drain();
        end

        repeat (20) @(posedge aclk);
        if (err_count == 0)
            $display("page_frame_buffer_bit_writer_tb: clean");
        else
            $display("page_frame_buffer_bit_writer_tb: errors");
        $finish;
    end

    // Guard against a hang.
    initial begin
        #4_000_000;
        $display("page_frame_buffer_bit_writer_tb: errors");
        $finish;
    end

endmodule
